// ===== sv/rgb2hsv_pkg.sv =====
// RGB to HSV conversion: shared constants, payload types and sideband types.
// No dependencies; imported by every module of the block except the generic divider.
package rgb2hsv_pkg;

    localparam int COMP_W     = 8;
    localparam int HUE_W      = 15;
    localparam int COMP_MAX   = (1 << COMP_W) - 1;

    // 60 degrees in 1/64 degree units, and a full turn
    localparam int SIXTY_DEG  = 3840;
    localparam int FULL_TURN  = 6 * SIXTY_DEG;

    // Divider geometry: quotients never exceed SIXTY_DEG, so 12 bits cover both
    localparam int QUO_W      = $clog2(SIXTY_DEG + 1);
    localparam int HNUM_W     = COMP_W + QUO_W;
    localparam int SNUM_W     = 2 * COMP_W;
    localparam int DIV_STAGES = QUO_W;

    // Signed hue sum before wrap: -60 .. 300 degrees
    localparam int HSUM_W     = HUE_W + 1;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [COMP_W-1:0] saturation;
        logic [COMP_W-1:0] brightness;
    } hsv_t;

    // Per-pixel data carried alongside the dividers
    typedef struct packed {
        logic              grey;
        sector_t           sector;
        logic              neg;
        logic [COMP_W-1:0] bright;
    } side_t;

endpackage

// ===== sv/rgb2hsv_converter_top.sv =====
// RGB to HSV converter, fully pipelined: one pixel accepted every clock.
// Stages from start to done: 2 front stages, 12 divider stages
// (one quotient bit each), 1 output stage. busy is held low.
// Reset clears only the valid bits; data registers are not reset.
// Results appear on result for one cycle with done high and cannot be held.
module rgb_to_hsv_converter_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rgb2hsv_pkg::rgb_t pixel,
    output logic              done,
    output rgb2hsv_pkg::hsv_t result
);
    import rgb2hsv_pkg::*;

    logic              front_valid;
    side_t             front_side;
    logic [HNUM_W-1:0] hue_num;
    logic [COMP_W-1:0] hue_den;
    logic [SNUM_W-1:0] sat_num;
    logic [COMP_W-1:0] sat_den;
    logic [QUO_W-1:0]  hue_quo;
    logic [QUO_W-1:0]  sat_quo;

    logic [DIV_STAGES-1:0] valid_reg;
    side_t                 side_reg [DIV_STAGES];

    assign busy = 1'b0;

    rgb2hsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .pixel     (pixel),
        .out_valid (front_valid),
        .side      (front_side),
        .hue_num   (hue_num),
        .hue_den   (hue_den),
        .sat_num   (sat_num),
        .sat_den   (sat_den)
    );

    rgb2hsv_div #(
        .NUM_W (HNUM_W),
        .DEN_W (COMP_W),
        .QUO_W (QUO_W)
    ) u_hue_div (
        .clk (clk),
        .num (hue_num),
        .den (hue_den),
        .quo (hue_quo)
    );

    rgb2hsv_div #(
        .NUM_W (SNUM_W),
        .DEN_W (COMP_W),
        .QUO_W (QUO_W)
    ) u_sat_div (
        .clk (clk),
        .num (sat_num),
        .den (sat_den),
        .quo (sat_quo)
    );

    // sideband line matched to the divider depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], front_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= front_side;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    rgb2hsv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_reg[DIV_STAGES-1]),
        .side     (side_reg[DIV_STAGES-1]),
        .hue_quo  (hue_quo),
        .sat_quo  (sat_quo),
        .done     (done),
        .result   (result)
    );

endmodule

// ===== sv/rgb2hsv_front.sv =====
// Front end: max/min, hue sector, signed difference, then divider numerators.
// Two register stages. Depends on rgb2hsv_pkg.
module rgb2hsv_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  rgb2hsv_pkg::rgb_t          pixel,
    output logic                       out_valid,
    output rgb2hsv_pkg::side_t         side,
    output logic [rgb2hsv_pkg::HNUM_W-1:0] hue_num,
    output logic [rgb2hsv_pkg::COMP_W-1:0] hue_den,
    output logic [rgb2hsv_pkg::SNUM_W-1:0] sat_num,
    output logic [rgb2hsv_pkg::COMP_W-1:0] sat_den
);
    import rgb2hsv_pkg::*;

    logic [COMP_W-1:0] max_next;
    logic [COMP_W-1:0] min_next;
    logic [COMP_W-1:0] opa;
    logic [COMP_W-1:0] opb;
    sector_t           sect_next;
    logic              neg_next;
    logic [COMP_W-1:0] mag_next;

    logic              valid1_reg;
    logic [COMP_W-1:0] bright1_reg;
    logic [COMP_W-1:0] delta1_reg;
    logic [COMP_W-1:0] mag1_reg;
    logic              neg1_reg;
    sector_t           sect1_reg;

    side_t             side2_next;
    logic              valid2_reg;
    side_t             side2_reg;
    logic [HNUM_W-1:0] hnum2_reg;
    logic [SNUM_W-1:0] snum2_reg;
    logic [COMP_W-1:0] hden2_reg;

    always_comb
    begin
        max_next = pixel.red;
        if (pixel.green > max_next)
        begin
            max_next = pixel.green;
        end
        if (pixel.blue > max_next)
        begin
            max_next = pixel.blue;
        end
        min_next = pixel.red;
        if (pixel.green < min_next)
        begin
            min_next = pixel.green;
        end
        if (pixel.blue < min_next)
        begin
            min_next = pixel.blue;
        end

        // ties: red over green over blue
        priority if (max_next == pixel.red)
        begin
            sect_next = SECT_RED;
            opa       = pixel.green;
            opb       = pixel.blue;
        end
        else if (max_next == pixel.green)
        begin
            sect_next = SECT_GREEN;
            opa       = pixel.blue;
            opb       = pixel.red;
        end
        else
        begin
            sect_next = SECT_BLUE;
            opa       = pixel.red;
            opb       = pixel.green;
        end

        neg_next = (opa < opb);
        mag_next = neg_next ? (opb - opa) : (opa - opb);
    end

    always_comb
    begin
        side2_next.grey   = (delta1_reg == '0);
        side2_next.sector = sect1_reg;
        side2_next.neg    = neg1_reg;
        side2_next.bright = bright1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bright1_reg <= max_next;
        delta1_reg  <= max_next - min_next;
        mag1_reg    <= mag_next;
        neg1_reg    <= neg_next;
        sect1_reg   <= sect_next;

        side2_reg   <= side2_next;
        hnum2_reg   <= HNUM_W'(mag1_reg) * HNUM_W'(SIXTY_DEG);
        snum2_reg   <= SNUM_W'(delta1_reg) * SNUM_W'(COMP_MAX);
        hden2_reg   <= delta1_reg;
    end

    assign out_valid = valid2_reg;
    assign side      = side2_reg;
    assign hue_num   = hnum2_reg;
    assign hue_den   = hden2_reg;
    assign sat_num   = snum2_reg;
    assign sat_den   = side2_reg.bright;

endmodule

// ===== sv/rgb2hsv_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Requires num < den * 2**QUO_W. Generic; no package dependency.
module rgb2hsv_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 8,
    parameter int QUO_W = 12
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic             fits;

        if (i == 0)
        begin : g_first
            // top bits are already below den, given the quotient range
            assign rem_in = DEN_W'(num >> QUO_W);
            assign low_in = num[QUO_W-1:0];
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign trial = {rem_in, low_in[QUO_W-1]};
        assign fits  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= fits ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
            low_reg[i] <= low_in << 1;
            den_reg[i] <= den_in;
            quo_reg[i] <= {quo_in[QUO_W-2:0], fits};
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

// ===== sv/rgb2hsv_back.sv =====
// Back end: signs the hue quotient, adds the sector offset, wraps, registers result.
// Depends on rgb2hsv_pkg.
module rgb2hsv_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  rgb2hsv_pkg::side_t            side,
    input  logic [rgb2hsv_pkg::QUO_W-1:0] hue_quo,
    input  logic [rgb2hsv_pkg::QUO_W-1:0] sat_quo,
    output logic                          done,
    output rgb2hsv_pkg::hsv_t             result
);
    import rgb2hsv_pkg::*;

    logic [HSUM_W-1:0] mag;
    logic [HSUM_W-1:0] offs;
    logic [HSUM_W-1:0] base;
    logic [HSUM_W-1:0] sum;
    hsv_t              result_next;
    logic              done_reg;
    hsv_t              result_reg;

    always_comb
    begin
        mag  = HSUM_W'(hue_quo);
        offs = side.neg ? (~mag + HSUM_W'(1)) : mag;
        unique case (side.sector)
            SECT_RED:   base = '0;
            SECT_GREEN: base = HSUM_W'(2 * SIXTY_DEG);
            SECT_BLUE:  base = HSUM_W'(4 * SIXTY_DEG);
            default:    base = '0;
        endcase
        sum = base + offs;
        // only the red sector can go negative; a zero quotient stays zero
        if (side.sector == SECT_RED && sum[HSUM_W-1])
        begin
            sum = sum + HSUM_W'(FULL_TURN);
        end

        result_next.brightness = side.bright;
        if (side.grey)
        begin
            result_next.hue        = '0;
            result_next.saturation = '0;
        end
        else
        begin
            result_next.hue        = sum[HUE_W-1:0];
            result_next.saturation = sat_quo[COMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
